// ===== design/ttc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttc_pkg - text terminal cursor controller types
// Command and action codes, control characters and the display beat format.
// ----------------------------------------------------------------------------
package ttc_pkg;

    typedef enum logic [2:0] {
        CMD_WRITE        = 3'd0,
        CMD_CLEAR_CELL   = 3'd1,
        CMD_SCROLL       = 3'd2,
        CMD_CLEAR_SCREEN = 3'd3,
        CMD_SET_CURSOR   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_MOVE  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;

    typedef struct packed {
        t_cmd        cmd;
        logic [6:0]  col;
        logic [4:0]  row;
        logic [15:0] word;
        logic        last;
    } t_beat;

    typedef struct packed {
        t_beat [2:0] beats;
        logic  [1:0] count;
        logic  [6:0] col;
        logic  [4:0] row;
    } t_plan;

endpackage

// ===== design/ttc_decode.sv =====
// ----------------------------------------------------------------------------
// ttc_decode - request decoder
// Turns one request and the current cursor into up to three display beats
// and the next cursor position.
// ----------------------------------------------------------------------------
module ttc_decode #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic [1:0]    i_action,
    input  logic [7:0]    i_char_code,
    input  logic [6:0]    i_target_col,
    input  logic [4:0]    i_target_row,
    input  logic [6:0]    i_cur_col,
    input  logic [4:0]    i_cur_row,
    input  logic [7:0]    i_color,
    output ttc_pkg::t_plan o_plan
);
    import ttc_pkg::*;

    localparam logic [6:0] LastCol = 7'(COLUMNS - 1);
    localparam logic [4:0] LastRow = 5'(ROWS - 1);
    localparam logic [7:0] ColLim  = 8'(COLUMNS);
    localparam logic [5:0] RowLim  = 6'(ROWS);

    logic [15:0] fill;
    logic        has_first;
    logic        has_scroll;
    t_beat       first;
    t_beat       scroll;
    t_beat       setc;
    logic [7:0]  col_a;
    logic [5:0]  row_a;
    logic [7:0]  col_b;
    logic [5:0]  row_b;
    logic [6:0]  col_f;
    logic [4:0]  row_f;

    assign fill = {i_color, 8'h00};

    always_comb begin
        has_first  = 1'b0;
        has_scroll = 1'b0;
        first      = '{cmd: CMD_WRITE, col: i_cur_col, row: i_cur_row,
                       word: {i_color, i_char_code}, last: 1'b0};
        col_a      = {1'b0, i_cur_col};
        row_a      = {1'b0, i_cur_row};
        col_b      = col_a;
        row_b      = row_a;
        col_f      = i_cur_col;
        row_f      = i_cur_row;
        case (i_action)
            ACT_PUT: begin
                if (i_char_code == CH_NEWLINE || i_char_code == CH_RETURN) begin
                    col_a = 8'd0;
                    row_a = row_a + 6'd1;
                end else if (i_char_code == CH_BACKSPACE) begin
                    if (i_cur_col != 7'd0 || i_cur_row != 5'd0) begin
                        if (i_cur_col == 7'd0) begin
                            row_a = row_a - 6'd1;
                            col_a = {1'b0, LastCol};
                        end else begin
                            col_a = col_a - 8'd1;
                        end
                        has_first = 1'b1;
                        first     = '{cmd: CMD_CLEAR_CELL, col: col_a[6:0],
                                      row: row_a[4:0], word: fill, last: 1'b0};
                    end
                end else begin
                    has_first = 1'b1;
                    col_a     = col_a + 8'd1;
                end
                col_b = col_a;
                row_b = row_a;
                if (col_a >= ColLim) begin
                    col_b = 8'd0;
                    row_b = row_a + 6'd1;
                end
                col_f = col_b[6:0];
                row_f = row_b[4:0];
                if (row_b >= RowLim) begin
                    has_scroll = 1'b1;
                    col_f      = 7'd0;
                    row_f      = LastRow;
                end
            end
            ACT_MOVE: begin
                col_f = ({1'b0, i_target_col} >= ColLim) ? LastCol : i_target_col;
                row_f = ({1'b0, i_target_row} >= RowLim) ? LastRow : i_target_row;
            end
            ACT_CLEAR: begin
                has_first = 1'b1;
                first     = '{cmd: CMD_CLEAR_SCREEN, col: 7'd0, row: 5'd0,
                              word: fill, last: 1'b0};
                col_f     = 7'd0;
                row_f     = 5'd0;
            end
            default: begin
                col_f = i_cur_col;
                row_f = i_cur_row;
            end
        endcase
    end

    assign scroll = '{cmd: CMD_SCROLL, col: 7'd0, row: 5'd0, word: fill, last: 1'b0};
    assign setc   = '{cmd: CMD_SET_CURSOR, col: col_f, row: row_f, word: 16'd0, last: 1'b1};

    always_comb begin
        o_plan.beats[0] = has_first ? first : (has_scroll ? scroll : setc);
        o_plan.beats[1] = has_first ? (has_scroll ? scroll : setc) : setc;
        o_plan.beats[2] = setc;
        o_plan.count    = 2'd1 + {1'b0, has_first} + {1'b0, has_scroll};
        o_plan.col      = col_f;
        o_plan.row      = row_f;
    end

endmodule

// ===== design/text_terminal_cursor_controller.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cursor_controller - text cursor and display command source
// Keeps the cursor of a character screen and issues display command beats.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on i_valid/o_ready with action, character and move target.
//   Each request gives one to three command beats on o_valid/i_ready; the
//   final beat is always set-cursor and carries o_last_command.
//   i_cfg_wr_en writes the attribute byte; write it only while the block is
//   idle.
//   An accepted request goes into the command list, and its first beat
//   then into the output register. Beats follow one per cycle while the
//   receiver does not stall, 1 to 3 per request. The rate is set by the
//   single command output; a new request is taken in the cycle its
//   predecessor's last beat moves into the output register.
//   Reset (synchronous, active low) homes the cursor, sets the attribute to 7
//   and drops any pending beats.
//   When the receiver stalls, the output register holds its beat and the
//   pending beats wait in the command list and block new requests.
// ----------------------------------------------------------------------------
module text_terminal_cursor_controller #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_target_col,
    input  logic [4:0]  i_target_row,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_command,
    output logic [6:0]  o_cell_col,
    output logic [4:0]  o_cell_row,
    output logic [15:0] o_cell_word,
    output logic        o_last_command
);
    import ttc_pkg::*;

    logic [7:0]  r_color;
    logic [6:0]  r_col;
    logic [4:0]  r_row;
    t_beat [2:0] r_list;
    logic [1:0]  r_rem;
    logic [1:0]  r_pos;
    t_beat       r_out;
    logic        r_out_valid;

    t_plan       plan;
    t_beat       head;
    logic        load_out;
    logic        accept;

    ttc_decode #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_decode (
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_target_col (i_target_col),
        .i_target_row (i_target_row),
        .i_cur_col    (r_col),
        .i_cur_row    (r_row),
        .i_color      (r_color),
        .o_plan       (plan)
    );

    always_comb begin
        case (r_pos)
            2'd0:    head = r_list[0];
            2'd1:    head = r_list[1];
            default: head = r_list[2];
        endcase
    end

    assign load_out = (r_rem != 2'd0) && (!r_out_valid || i_ready);
    assign o_ready  = (r_rem == 2'd0) || (r_rem == 2'd1 && load_out);
    assign accept   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= 8'd7;
            r_col       <= 7'd0;
            r_row       <= 5'd0;
            r_rem       <= 2'd0;
            r_pos       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_color <= i_cfg_wr_data;
            end
            // take a request, or advance through the pending beats
            if (accept) begin
                r_list <= plan.beats;
                r_rem  <= plan.count;
                r_pos  <= 2'd0;
                r_col  <= plan.col;
                r_row  <= plan.row;
            end else if (load_out) begin
                r_rem <= r_rem - 2'd1;
                r_pos <= r_pos + 2'd1;
            end
            // hold the output beat until taken
            if (load_out) begin
                r_out       <= head;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_command      = r_out.cmd;
    assign o_cell_col     = r_out.col;
    assign o_cell_row     = r_out.row;
    assign o_cell_word    = r_out.word;
    assign o_last_command = r_out.last;

`ifndef SYNTH
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_rem != 2'd0)
        else $error("accepted request left no pending beats");

    a_last_is_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_command |-> o_command == CMD_SET_CURSOR)
        else $error("final beat is not set-cursor");

    a_final_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && r_rem == 2'd1 |=> o_valid && o_last_command)
        else $error("final pending beat lacks last flag");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < 8'(COLUMNS)) && ({1'b0, r_row} < 6'(ROWS)))
        else $error("cursor off screen");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb - text terminal cursor controller testbench
// Drives requests with random gaps against a receiver that stalls at random,
// and follows the cursor in a local model of the display command stream.
// Every command beat is compared field by field with the next expected one.
// Directed cases cover control characters, wrap, scroll and saturation;
// random traffic, back-to-back bursts and a long output stall follow.
// ----------------------------------------------------------------------------
module tb;
    import ttc_pkg::*;

    localparam int COLS        = 80;
    localparam int ROWS        = 25;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 4;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_action;
    logic [7:0]  i_char_code;
    logic [6:0]  i_target_col;
    logic [4:0]  i_target_row;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_command;
    logic [6:0]  o_cell_col;
    logic [4:0]  o_cell_row;
    logic [15:0] o_cell_word;
    logic        o_last_command;

    t_beat       due_cmds[$];
    logic [7:0]  text_attr;
    logic [6:0]  cur_col;
    logic [4:0]  cur_row;
    logic        send_gaps;
    logic        sink_stalls;
    logic        offering;
    int          hold_request;
    int          mismatches;
    int          cmds_seen;
    int          requests_sent;
    int          scrolls_planned;
    int          colour_writes;

    text_terminal_cursor_controller #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_char_code    (i_char_code),
        .i_target_col   (i_target_col),
        .i_target_row   (i_target_row),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_command      (o_command),
        .o_cell_col     (o_cell_col),
        .o_cell_row     (o_cell_row),
        .o_cell_word    (o_cell_word),
        .o_last_command (o_last_command)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void push_cmd(input t_cmd cmd, input logic [6:0] col,
                                     input logic [4:0] row, input logic [15:0] word,
                                     input logic last);
        t_beat b;
        b.cmd  = cmd;
        b.col  = col;
        b.row  = row;
        b.word = word;
        b.last = last;
        due_cmds.push_back(b);
    endfunction

    function automatic void plan_commands(input logic [1:0] act, input logic [7:0] ch,
                                          input logic [6:0] tcol, input logic [4:0] trow);
        logic [15:0] fill;
        fill = {text_attr, 8'h00};
        case (act)
            ACT_PUT: begin
                if (ch == CH_NEWLINE || ch == CH_RETURN) begin
                    cur_col = '0;
                    cur_row = cur_row + 5'd1;
                end else if (ch == CH_BACKSPACE) begin
                    if (cur_col != 0 || cur_row != 0) begin
                        if (cur_col == 0) begin
                            cur_row = cur_row - 5'd1;
                            cur_col = 7'(COLS);
                        end
                        cur_col = cur_col - 7'd1;
                        push_cmd(CMD_CLEAR_CELL, cur_col, cur_row, fill, 1'b0);
                    end
                end else begin
                    push_cmd(CMD_WRITE, cur_col, cur_row, {text_attr, ch}, 1'b0);
                    cur_col = cur_col + 7'd1;
                end
                if (cur_col >= COLS) begin
                    cur_col = '0;
                    cur_row = cur_row + 5'd1;
                end
                if (cur_row >= ROWS) begin
                    push_cmd(CMD_SCROLL, '0, '0, fill, 1'b0);
                    cur_row = 5'(ROWS - 1);
                    cur_col = '0;
                    scrolls_planned++;
                end
            end
            ACT_MOVE: begin
                cur_col = (tcol >= COLS) ? 7'(COLS - 1) : tcol;
                cur_row = (trow >= ROWS) ? 5'(ROWS - 1) : trow;
            end
            ACT_CLEAR: begin
                push_cmd(CMD_CLEAR_SCREEN, '0, '0, fill, 1'b0);
                cur_col = '0;
                cur_row = '0;
            end
            default: ;
        endcase
        push_cmd(CMD_SET_CURSOR, cur_col, cur_row, 16'h0000, 1'b1);
    endfunction

    task automatic send_request(input logic [1:0] act, input logic [7:0] ch,
                                input logic [6:0] tcol, input logic [4:0] trow);
        int gap;
        gap = send_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_char_code  <= ch;
        i_target_col <= tcol;
        i_target_row <= trow;
        offering = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        plan_commands(act, ch, tcol, trow);
        requests_sent++;
    endtask

    task automatic send_random_request();
        int pick;
        int sub;
        logic [1:0] act;
        logic [7:0] ch;
        logic [6:0] tcol;
        logic [4:0] trow;
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        tcol = 7'($urandom_range(0, 127));
        trow = 5'($urandom_range(0, 31));
        if (pick < 62) begin
            act = ACT_PUT;
            if (sub < 10)
                ch = CH_NEWLINE;
            else if (sub < 15)
                ch = CH_RETURN;
            else if (sub < 30)
                ch = CH_BACKSPACE;
        end else if (pick < 88) begin
            act = ACT_MOVE;
            if (sub < 35) begin
                // steer towards the right edge and bottom rows
                tcol = 7'($urandom_range(COLS - 4, COLS - 1));
                trow = 5'($urandom_range(ROWS - 2, ROWS - 1));
            end else if (sub < 80) begin
                tcol = 7'($urandom_range(0, COLS - 1));
                trow = 5'($urandom_range(0, ROWS - 1));
            end
        end else if (pick < 96) begin
            act = ACT_CLEAR;
        end else begin
            act = ACT_UNUSED;
        end
        send_request(act, ch, tcol, trow);
    endtask

    task automatic wait_idle();
        if (offering) begin
            i_valid <= 1'b0;
            offering = 1'b0;
        end
        while (due_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_colour(input logic [7:0] attr);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= attr;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        text_attr = attr;
        colour_writes++;
    endtask

    task automatic test_directed_cases();
        send_request(ACT_PUT, 8'h41, 7'd0, 5'd0);
        send_request(ACT_PUT, 8'hFF, 7'd127, 5'd31);
        send_request(ACT_PUT, 8'h00, 7'd0, 5'd0);
        send_request(ACT_PUT, CH_BACKSPACE, 7'd0, 5'd0);
        send_request(ACT_PUT, CH_NEWLINE, 7'd0, 5'd0);
        send_request(ACT_PUT, CH_BACKSPACE, 7'd0, 5'd0);
        send_request(ACT_PUT, CH_RETURN, 7'd0, 5'd0);
        send_request(ACT_MOVE, 8'h00, 7'd0, 5'd0);
        send_request(ACT_PUT, CH_BACKSPACE, 7'd0, 5'd0);
        send_request(ACT_MOVE, 8'hFF, 7'd127, 5'd31);
        send_request(ACT_PUT, 8'h5A, 7'd0, 5'd0);
        send_request(ACT_PUT, CH_NEWLINE, 7'd0, 5'd0);
        send_request(ACT_PUT, CH_BACKSPACE, 7'd0, 5'd0);
        send_request(ACT_MOVE, 8'h00, 7'd78, 5'd10);
        send_request(ACT_PUT, 8'h61, 7'd0, 5'd0);
        send_request(ACT_PUT, 8'h62, 7'd0, 5'd0);
        send_request(ACT_MOVE, 8'h00, 7'd40, 5'd12);
        send_request(ACT_CLEAR, 8'hFF, 7'd127, 5'd31);
        send_request(ACT_UNUSED, 8'h00, 7'd0, 5'd0);
        send_request(ACT_MOVE, 8'h00, 7'(COLS), 5'(ROWS));
        send_request(ACT_UNUSED, 8'hFF, 7'd127, 5'd31);
        wait_idle();
    endtask

    task automatic test_random_traffic(input logic [7:0] attr, input int count);
        write_colour(attr);
        repeat (count) send_random_request();
        wait_idle();
    endtask

    task automatic test_back_to_back(input int count);
        write_colour(8'h00);
        send_gaps   = 1'b0;
        sink_stalls = 1'b0;
        repeat (count) send_random_request();
        wait_idle();
        send_gaps   = 1'b1;
        sink_stalls = 1'b1;
    endtask

    task automatic test_output_stall(input int count);
        write_colour(8'($urandom_range(0, 255)));
        send_gaps    = 1'b0;
        hold_request = 80;
        repeat (count) send_random_request();
        wait_idle();
        send_gaps = 1'b1;
    endtask

    // receiver: draw a stall per beat, honour a requested long hold-off
    initial begin : sink
        int stall;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = sink_stalls ? $urandom_range(0, 9) : 0;
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin : check_cmds
        t_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            cmds_seen++;
            if (due_cmds.size() == 0) begin
                if (mismatches < 10)
                    $display("tb: unexpected beat cmd=%0d col=%0d row=%0d word=%h last=%b",
                             o_command, o_cell_col, o_cell_row, o_cell_word, o_last_command);
                mismatches++;
            end else begin
                want = due_cmds.pop_front();
                if (o_command !== want.cmd || o_cell_col !== want.col ||
                    o_cell_row !== want.row || o_cell_word !== want.word ||
                    o_last_command !== want.last) begin
                    if (mismatches < 10)
                        $display({"tb: mismatch exp cmd=%0d col=%0d row=%0d word=%h last=%b",
                                  " got cmd=%0d col=%0d row=%0d word=%h last=%b"},
                                 want.cmd, want.col, want.row, want.word, want.last,
                                 o_command, o_cell_col, o_cell_row, o_cell_word,
                                 o_last_command);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 8'h00;
        i_valid       <= 1'b0;
        i_action      <= ACT_PUT;
        i_char_code   <= 8'h00;
        i_target_col  <= 7'd0;
        i_target_row  <= 5'd0;
        text_attr       = 8'd7;
        cur_col         = '0;
        cur_row         = '0;
        send_gaps       = 1'b1;
        sink_stalls     = 1'b1;
        offering        = 1'b0;
        hold_request    = 0;
        mismatches      = 0;
        cmds_seen       = 0;
        requests_sent   = 0;
        scrolls_planned = 0;
        colour_writes   = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(8'hFF, 100);
        test_back_to_back(50);
        test_output_stall(40);
        test_random_traffic(8'h1E, 60);

        repeat (8) @(posedge i_clk);
        mismatches += due_cmds.size();
        $display("tb: %0d requests, %0d command beats checked, %0d scrolls, %0d attribute writes",
                 requests_sent, cmds_seen, scrolls_planned, colour_writes);
        $display("tb: covered control characters, wrap, saturation, bursts and a long stall");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
